FILE: sv/d2_window_score_engine_unit_macros.svh
// Assertion macros for the d2 window score engine.
// Expects clk and rst_n in the scope where they are used.
`ifndef D2_WINDOW_SCORE_ENGINE_UNIT_MACROS_SVH
`define D2_WINDOW_SCORE_ENGINE_UNIT_MACROS_SVH

// Same-cycle implication, masked during reset.
`define D2WS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked during reset.
`define D2WS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/d2ws_pkg.sv
// Shared types and constants of the d2 window score engine.
// No dependencies; the interfaces, the top level, the sequencer and the bench import it.
package d2ws_pkg;

    localparam int CMD_BITS       = 2;
    localparam int WORD_BITS      = 12;
    localparam int SCORE_BITS     = 17;
    localparam int KMER_LEN_DEF   = 6;
    localparam int COUNT_BITS_DEF = 9;

    localparam logic [SCORE_BITS-1:0] THR_RESET = SCORE_BITS'(40);

    typedef enum logic [CMD_BITS-1:0] {
        CMD_UPDATE_MIN  = 2'd0,
        CMD_UPDATE      = 2'd1,
        CMD_RESTART_MIN = 2'd2,
        CMD_CLEAR       = 2'd3
    } cmd_t;

    typedef logic [SCORE_BITS-1:0] score_t;

    typedef struct packed {
        score_t score;
        score_t least_score;
        logic   overflow;
    } res_t;

    typedef struct packed {
        logic clearing;
        logic res_valid;
    } ctrl_stat_t;

endpackage

FILE: sv/d2ws_if.sv
// Valid/ready channels of the d2 window score engine: update items and results.
// Depends on d2ws_pkg for field widths.
interface d2ws_in_if;
    import d2ws_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CMD_BITS-1:0]  cmd;
    logic [WORD_BITS-1:0] inc_word;
    logic [WORD_BITS-1:0] dec_word;

    modport source (output valid, output cmd, output inc_word, output dec_word,
                    input ready);
    modport sink   (input valid, input cmd, input inc_word, input dec_word,
                    output ready);
endinterface

interface d2ws_out_if;
    import d2ws_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [SCORE_BITS-1:0] score;
    logic [SCORE_BITS-1:0] least_score;
    logic                  score_hit;
    logic                  min_hit;
    logic                  overflow;

    modport source (output valid, output score, output least_score, output score_hit,
                    output min_hit, output overflow, input ready);
    modport sink   (input valid, input score, input least_score, input score_hit,
                    input min_hit, input overflow, output ready);
endinterface

FILE: sv/d2_window_score_engine_unit.sv
// Top level of the d2 window score engine: threshold register, output register,
// count table and update sequencer. Uses d2ws_pkg, d2ws_if, d2ws_count_mem, d2ws_ctrl.
//
// Keeps a signed difference count per word in a 4^KMER_LEN-entry table and the
// running d2 score; one result per item. An update with distinct words runs in steps
// (accept and read both counts, write the rising count, write the falling count,
// load the result), since the table has a single write port. Equal words,
// restart-min and clear go from accept straight to loading the result. After reset,
// and after every clear command, a sweep zeroes all 4^KMER_LEN entries (4096 by default)
// one entry a cycle; no item is taken during it, threshold writes are. A new item is
// taken while the previous result still waits at the output.
`include "d2_window_score_engine_unit_macros.svh"

module d2_window_score_engine_unit #(
    parameter int KMER_LEN   = d2ws_pkg::KMER_LEN_DEF,
    parameter int COUNT_BITS = d2ws_pkg::COUNT_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    d2ws_in_if.sink                       item,
    d2ws_out_if.source                    result,
    input  logic                          cfg_wr_en,
    input  logic [d2ws_pkg::SCORE_BITS-1:0] cfg_wr_data
);
    import d2ws_pkg::*;

    localparam int ADDR_BITS = 2 * KMER_LEN;

    score_t               threshold_reg;
    logic                 out_valid_reg;
    res_t                 out_res_reg;
    logic                 score_hit_reg;
    logic                 min_hit_reg;

    logic                 out_free;
    ctrl_stat_t           stat;
    res_t                 res;

    logic                 rd_en;
    logic [ADDR_BITS-1:0] rd_addr_a;
    logic [ADDR_BITS-1:0] rd_addr_b;
    logic [COUNT_BITS:0]  rd_data_a;
    logic [COUNT_BITS:0]  rd_data_b;
    logic                 wr_en;
    logic [ADDR_BITS-1:0] wr_addr;
    logic [COUNT_BITS:0]  wr_data;

    assign out_free = !out_valid_reg || result.ready;

    d2ws_ctrl #(
        .KMER_LEN   (KMER_LEN),
        .COUNT_BITS (COUNT_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .out_free  (out_free),
        .stat      (stat),
        .res       (res),
        .rd_en     (rd_en),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    d2ws_count_mem #(
        .ADDR_BITS (ADDR_BITS),
        .DATA_BITS (COUNT_BITS + 1)
    ) u_count_mem (
        .clk       (clk),
        .rd_en     (rd_en),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THR_RESET;
        end
        else if (cfg_wr_en)
        begin
            threshold_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (stat.res_valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stat.res_valid)
        begin
            out_res_reg   <= res;
            score_hit_reg <= (res.score <= threshold_reg);
            min_hit_reg   <= (res.least_score <= threshold_reg);
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.score       = out_res_reg.score;
    assign result.least_score = out_res_reg.least_score;
    assign result.score_hit   = score_hit_reg;
    assign result.min_hit     = min_hit_reg;
    assign result.overflow    = out_res_reg.overflow;

    `D2WS_ASSERT_NOW(a_load_needs_room, stat.res_valid, !out_valid_reg || result.ready, "result loaded over a waiting one")
    `D2WS_ASSERT_NOW(a_no_item_in_sweep, stat.clearing, !item.ready, "item taken during table sweep")
    `D2WS_ASSERT_NEXT(a_one_item_at_a_time, item.valid && item.ready, !item.ready, "item taken while previous one in flight")

endmodule

FILE: sv/d2ws_count_mem.sv
// Count table: one write port, two registered read ports.
// Each entry holds a valid flag above a signed difference count; no dependencies.
module d2ws_count_mem #(
    parameter int ADDR_BITS = 12,
    parameter int DATA_BITS = 10
) (
    input  logic                 clk,
    input  logic                 rd_en,
    input  logic [ADDR_BITS-1:0] rd_addr_a,
    input  logic [ADDR_BITS-1:0] rd_addr_b,
    output logic [DATA_BITS-1:0] rd_data_a,
    output logic [DATA_BITS-1:0] rd_data_b,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [DATA_BITS-1:0] wr_data
);

    localparam int DEPTH = 1 << ADDR_BITS;

    logic [DATA_BITS-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

FILE: sv/d2ws_ctrl.sv
// Update sequencer: reads both counts, applies the rising then the falling half,
// writes each entry back and tracks score, minimum and overflow. Uses d2ws_pkg.
module d2ws_ctrl #(
    parameter int KMER_LEN   = d2ws_pkg::KMER_LEN_DEF,
    parameter int COUNT_BITS = d2ws_pkg::COUNT_BITS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    d2ws_in_if.sink                 item,
    input  logic                    out_free,
    output d2ws_pkg::ctrl_stat_t    stat,
    output d2ws_pkg::res_t          res,
    output logic                    rd_en,
    output logic [2*KMER_LEN-1:0]   rd_addr_a,
    output logic [2*KMER_LEN-1:0]   rd_addr_b,
    input  logic [COUNT_BITS:0]     rd_data_a,
    input  logic [COUNT_BITS:0]     rd_data_b,
    output logic                    wr_en,
    output logic [2*KMER_LEN-1:0]   wr_addr,
    output logic [COUNT_BITS:0]     wr_data
);
    import d2ws_pkg::*;

    localparam int ADDR_BITS = 2 * KMER_LEN;
    localparam int EXT_BITS  = (ADDR_BITS > WORD_BITS) ? ADDR_BITS : WORD_BITS;
    localparam int SUM_BITS  =
        ((COUNT_BITS + 2 > SCORE_BITS + 1) ? COUNT_BITS + 2 : SCORE_BITS + 1) + 1;

    typedef logic signed [COUNT_BITS-1:0] count_t;
    typedef logic signed [SUM_BITS-1:0]   sum_t;

    localparam count_t COUNT_MAX = {1'b0, {(COUNT_BITS-1){1'b1}}};
    localparam count_t COUNT_MIN = {1'b1, {(COUNT_BITS-1){1'b0}}};
    localparam count_t COUNT_ONE = COUNT_BITS'(1);
    localparam sum_t   SUM_ONE   = SUM_BITS'(1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_INC,
        S_DEC,
        S_DONE
    } state_t;

    state_t                 state_reg;
    logic [ADDR_BITS-1:0]   clr_addr_reg;
    score_t                 score_reg;
    score_t                 min_reg;
    logic                   ovf_reg;
    cmd_t                   cmd_reg;
    logic [ADDR_BITS-1:0]   inc_addr_reg;
    logic [ADDR_BITS-1:0]   dec_addr_reg;

    logic                   accept;
    cmd_t                   item_cmd;
    logic [EXT_BITS-1:0]    inc_ext;
    logic [EXT_BITS-1:0]    dec_ext;
    logic [ADDR_BITS-1:0]   inc_addr;
    logic [ADDR_BITS-1:0]   dec_addr;

    logic                   up;
    logic [COUNT_BITS:0]    entry;
    count_t                 d;
    count_t                 new_cnt;
    logic                   at_limit;
    sum_t                   d_ext;
    sum_t                   score_ext;
    sum_t                   step;
    sum_t                   ns;
    logic                   apply;
    score_t                 min_next;

    assign item.ready = (state_reg == S_IDLE);
    assign accept     = item.valid && item.ready;
    assign item_cmd   = cmd_t'(item.cmd);

    assign inc_ext  = EXT_BITS'(item.inc_word);
    assign dec_ext  = EXT_BITS'(item.dec_word);
    assign inc_addr = inc_ext[ADDR_BITS-1:0];
    assign dec_addr = dec_ext[ADDR_BITS-1:0];

    // One half-update per cycle: rising word in S_INC, falling word in S_DEC.
    always_comb
    begin
        up        = (state_reg == S_INC);
        entry     = up ? rd_data_a : rd_data_b;
        d         = entry[COUNT_BITS] ? count_t'(entry[COUNT_BITS-1:0]) : '0;
        at_limit  = up ? (d == COUNT_MAX) : (d == COUNT_MIN);
        d_ext     = SUM_BITS'(d);
        score_ext = sum_t'({{(SUM_BITS-SCORE_BITS){1'b0}}, score_reg});
        step      = up ? ((d_ext <<< 1) + SUM_ONE) : (SUM_ONE - (d_ext <<< 1));
        ns        = score_ext + step;
        apply     = !at_limit && (ns[SUM_BITS-1:SCORE_BITS] == '0);
        new_cnt   = up ? (d + COUNT_ONE) : (d - COUNT_ONE);
    end

    always_comb
    begin
        rd_en     = accept;
        rd_addr_a = inc_addr;
        rd_addr_b = dec_addr;
        wr_en     = (state_reg == S_CLEAR)
                    || (((state_reg == S_INC) || (state_reg == S_DEC)) && apply);
        priority if (state_reg == S_CLEAR)
        begin
            wr_addr = clr_addr_reg;
            wr_data = '0;
        end
        else if (state_reg == S_INC)
        begin
            wr_addr = inc_addr_reg;
            wr_data = {1'b1, new_cnt};
        end
        else
        begin
            wr_addr = dec_addr_reg;
            wr_data = {1'b1, new_cnt};
        end
    end

    assign min_next = ((cmd_reg == CMD_UPDATE_MIN) && (score_reg < min_reg))
                      ? score_reg : min_reg;

    assign res.score       = score_reg;
    assign res.least_score = min_next;
    assign res.overflow    = ovf_reg;

    assign stat.clearing  = (state_reg == S_CLEAR);
    assign stat.res_valid = (state_reg == S_DONE) && out_free;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg      <= item_cmd;
            inc_addr_reg <= inc_addr;
            dec_addr_reg <= dec_addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            clr_addr_reg <= '0;
            score_reg    <= '0;
            min_reg      <= '0;
            ovf_reg      <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_addr_reg <= clr_addr_reg + 1'b1;
                    if (clr_addr_reg == '1)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        unique case (item_cmd)
                            CMD_CLEAR:
                            begin
                                score_reg <= '0;
                                min_reg   <= '0;
                                ovf_reg   <= 1'b0;
                                state_reg <= S_DONE;
                            end
                            CMD_RESTART_MIN:
                            begin
                                min_reg   <= score_reg;
                                state_reg <= S_DONE;
                            end
                            CMD_UPDATE_MIN, CMD_UPDATE:
                            begin
                                // equal words cancel: skip the table
                                state_reg <= (inc_addr == dec_addr) ? S_DONE : S_INC;
                            end
                        endcase
                    end
                end
                S_INC, S_DEC:
                begin
                    if (apply)
                    begin
                        score_reg <= ns[SCORE_BITS-1:0];
                    end
                    else
                    begin
                        ovf_reg <= 1'b1;
                    end
                    state_reg <= (state_reg == S_INC) ? S_DEC : S_DONE;
                end
                S_DONE:
                begin
                    // hold until the output register has room
                    if (out_free)
                    begin
                        min_reg <= min_next;
                        if (cmd_reg == CMD_CLEAR)
                        begin
                            clr_addr_reg <= '0;
                            state_reg    <= S_CLEAR;
                        end
                        else
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: sim/d2_window_score_engine_unit_test.sv
// Self-checking bench for d2_window_score_engine_unit: random valid/ready traffic on both
// channels, threshold writes between phases, and a scoreboard that predicts every result.
// Depends on d2ws_pkg, d2ws_if and the engine RTL.
`timescale 1ns / 1ps

module d2_window_score_engine_unit_test;
    import d2ws_pkg::*;

    localparam int TABLE_WORDS = 1 << (2 * KMER_LEN_DEF);
    localparam int COUNT_HI    = (1 << (COUNT_BITS_DEF - 1)) - 1;
    localparam int COUNT_LO    = -COUNT_HI - 1;
    localparam int SCORE_TOP   = (1 << SCORE_BITS) - 1;
    localparam int IDLE_PCT    = 38;
    localparam int HOLD_CYCLES = 200;
    localparam int SETTLE      = 8;
    localparam int RAMP_AB     = 258;
    localparam int RAMP_CD     = 30;

    typedef logic [WORD_BITS-1:0] word_t;

    typedef struct packed {
        score_t score;
        score_t least_score;
        logic   score_hit;
        logic   min_hit;
        logic   overflow;
    } score_report_t;

    class score_tracker;
        logic signed [COUNT_BITS_DEF-1:0] word_diff [TABLE_WORDS];
        score_t        running;
        score_t        least;
        score_t        thresh;
        bit            ovf_seen;
        score_report_t due[$];
        int            items_seen;
        int            results_seen;
        int            errors;
        int            overflow_reports;
        int            score_hits;

        function new();
            thresh = THR_RESET;
            wipe();
        endfunction

        function void wipe();
            foreach (word_diff[i]) word_diff[i] = '0;
            running  = '0;
            least    = '0;
            ovf_seen = 1'b0;
        endfunction

        // Refuse the half-update if either the count or the score would leave its range.
        function void bump_count(word_t w, bit up);
            int d;
            int ns;
            d = int'(word_diff[w]);
            if (up) begin
                if (d >= COUNT_HI) begin
                    ovf_seen = 1'b1;
                    return;
                end
                ns = int'(running) + 2 * d + 1;
            end
            else begin
                if (d <= COUNT_LO) begin
                    ovf_seen = 1'b1;
                    return;
                end
                ns = int'(running) - 2 * d + 1;
            end
            if (ns < 0 || ns > SCORE_TOP) begin
                ovf_seen = 1'b1;
                return;
            end
            running = score_t'(ns);
            word_diff[w] = COUNT_BITS_DEF'(up ? d + 1 : d - 1);
        endfunction

        function void note_item(cmd_t op, word_t wi, word_t wd);
            score_report_t r;
            case (op)
                CMD_CLEAR:       wipe();
                CMD_RESTART_MIN: least = running;
                default:
                begin
                    if (wi != wd) begin
                        bump_count(wi, 1'b1);
                        bump_count(wd, 1'b0);
                    end
                    if (op == CMD_UPDATE_MIN && running < least)
                        least = running;
                end
            endcase
            r.score       = running;
            r.least_score = least;
            r.score_hit   = (running <= thresh);
            r.min_hit     = (least <= thresh);
            r.overflow    = ovf_seen;
            due.push_back(r);
            items_seen++;
        endfunction

        function void match_field(string name, logic [SCORE_BITS-1:0] want,
                                  logic [SCORE_BITS-1:0] got);
            if (got !== want) begin
                $error("%s mismatch: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(score_report_t got);
            score_report_t want;
            results_seen++;
            if (got.overflow === 1'b1)
                overflow_reports++;
            if (got.score_hit === 1'b1)
                score_hits++;
            if (due.size() == 0) begin
                $error("result with nothing outstanding: score %0d", got.score);
                errors++;
                return;
            end
            want = due.pop_front();
            match_field("score", want.score, got.score);
            match_field("least_score", want.least_score, got.least_score);
            match_field("score_hit", score_t'(want.score_hit), score_t'(got.score_hit));
            match_field("min_hit", score_t'(want.min_hit), score_t'(got.min_hit));
            match_field("overflow", score_t'(want.overflow), score_t'(got.overflow));
        endfunction

        function int pending();
            return due.size();
        endfunction
    endclass

    logic   clk;
    logic   rst_n;
    logic   cfg_wr_en;
    score_t cfg_wr_data;

    d2ws_in_if  item_ch ();
    d2ws_out_if result_ch ();

    d2_window_score_engine_unit uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item_ch),
        .result      (result_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    score_tracker sb;
    bit sender_quiet;
    bit sink_quiet;
    bit hold_off_req;
    int thr_writes;
    int clears_sent;
    int clears_left;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

    // Result side: random back-pressure, with a long hold-off on each request.
    initial
    begin
        result_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                result_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else
                result_ch.ready <= sink_quiet || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    initial
    begin
        score_report_t got;
        forever begin
            @(posedge clk);
            if (rst_n && result_ch.valid && result_ch.ready) begin
                got.score       = result_ch.score;
                got.least_score = result_ch.least_score;
                got.score_hit   = result_ch.score_hit;
                got.min_hit     = result_ch.min_hit;
                got.overflow    = result_ch.overflow;
                sb.check_result(got);
            end
        end
    end

    function automatic word_t rand_word();
        return word_t'($urandom);
    endfunction

    // Returns at the rising edge of the transfer.
    task automatic send_item(cmd_t op, word_t wi, word_t wd);
        @(negedge clk);
        while (!sender_quiet && $urandom_range(99) < IDLE_PCT) begin
            item_ch.valid <= 1'b0;
            @(negedge clk);
        end
        item_ch.valid    <= 1'b1;
        item_ch.cmd      <= op;
        item_ch.inc_word <= wi;
        item_ch.dec_word <= wd;
        do @(posedge clk); while (!item_ch.ready);
        sb.note_item(op, wi, wd);
        if (op == CMD_CLEAR)
            clears_sent++;
    endtask

    task automatic release_items();
        @(negedge clk);
        item_ch.valid <= 1'b0;
    endtask

    task automatic drain();
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_threshold(score_t v);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        sb.thresh = v;
        thr_writes++;
    endtask

    // Push one word to its positive limit against another to its negative limit, then
    // grow a second pair until the score itself would pass its range.
    task automatic run_ramp();
        word_t wa;
        word_t wb;
        word_t wc;
        word_t wd;
        cmd_t  op;
        int    step;
        wa = rand_word();
        wb = wa + 12'd1 + word_t'($urandom_range(999));
        wc = wb + 12'd1 + word_t'($urandom_range(999));
        wd = wc + 12'd1 + word_t'($urandom_range(999));
        step = 0;
        while (step < RAMP_AB + RAMP_CD) begin
            sender_quiet = (step < 60) || (step >= 100 && step < 140);
            sink_quiet   = (step < 60);
            if (step == 100)
                hold_off_req = 1'b1;
            op = $urandom_range(1) ? CMD_UPDATE : CMD_UPDATE_MIN;
            if ($urandom_range(99) < 4)
                send_item(CMD_RESTART_MIN, rand_word(), rand_word());
            else if ($urandom_range(99) < 3)
                send_item(op, rand_word(), rand_word());
            else begin
                if (step < RAMP_AB)
                    send_item(op, wa, wb);
                else
                    send_item(op, wc, wd);
                step++;
            end
        end
        sender_quiet = 1'b0;
        sink_quiet   = 1'b0;
    endtask

    task automatic run_random_block(int n);
        word_t pool [6];
        word_t wi;
        word_t wd;
        cmd_t  op;
        int    r;
        foreach (pool[i]) pool[i] = rand_word();
        repeat (n) begin
            r = $urandom_range(99);
            if (r < 2 && clears_left > 0) begin
                op = CMD_CLEAR;
                clears_left--;
            end
            else if (r < 20)
                op = CMD_RESTART_MIN;
            else if (r < 55)
                op = CMD_UPDATE;
            else
                op = CMD_UPDATE_MIN;
            wi = pool[$urandom_range(5)];
            wd = pool[$urandom_range(5)];
            r = $urandom_range(99);
            if (r < 10)
                wd = wi;
            else if (r < 15) begin
                wi = rand_word();
                wd = rand_word();
            end
            send_item(op, wi, wd);
        end
    endtask

    initial
    begin
        score_t thr;
        sb = new();
        sender_quiet  = 1'b0;
        sink_quiet    = 1'b0;
        hold_off_req  = 1'b0;
        thr_writes    = 0;
        clears_sent   = 0;
        clears_left   = 12;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        item_ch.valid    = 1'b0;
        item_ch.cmd      = CMD_UPDATE_MIN;
        item_ch.inc_word = '0;
        item_ch.dec_word = '0;
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset threshold: word extremes, equal words, restart, update-only, clear.
        send_item(CMD_UPDATE_MIN, 12'h000, 12'hFFF);
        send_item(CMD_UPDATE, 12'hFFF, 12'h000);
        send_item(CMD_UPDATE_MIN, 12'hAAA, 12'hAAA);
        send_item(CMD_UPDATE_MIN, 12'h555, 12'hAAA);
        send_item(CMD_RESTART_MIN, 12'hFFF, 12'hFFF);
        send_item(CMD_UPDATE, 12'h555, 12'hAAA);
        send_item(CMD_UPDATE_MIN, 12'hAAA, 12'h555);
        send_item(CMD_CLEAR, 12'h5A5, 12'hA5A);
        send_item(CMD_UPDATE_MIN, 12'h001, 12'h002);
        release_items();
        drain();

        write_threshold('0);
        send_item(CMD_RESTART_MIN, 12'h000, 12'h000);
        send_item(CMD_UPDATE_MIN, 12'h002, 12'h001);
        send_item(CMD_UPDATE, 12'h800, 12'h7FF);
        release_items();
        drain();

        write_threshold('1);
        send_item(CMD_UPDATE_MIN, 12'h7FF, 12'h800);
        send_item(CMD_UPDATE, 12'hFFF, 12'h000);
        send_item(CMD_CLEAR, 12'hFFF, 12'hFFF);
        release_items();
        drain();

        // Scores near the top of the range against a high threshold.
        write_threshold(score_t'(130500));
        run_ramp();
        send_item(CMD_CLEAR, rand_word(), rand_word());
        release_items();
        drain();

        for (int b = 0; b < 9; b++) begin
            if (b == 0)
                thr = '0;
            else if (b == 1)
                thr = '1;
            else if ($urandom_range(1))
                thr = score_t'($urandom_range(300));
            else
                thr = score_t'($urandom);
            write_threshold(thr);
            run_random_block(15);
            release_items();
            drain();
        end

        $display("Covered %0d items and %0d results over %0d threshold settings, %0d clears.",
                 sb.items_seen, sb.results_seen, thr_writes, clears_sent);
        $display("Overflow flag on %0d results, score at or below threshold on %0d.",
                 sb.overflow_reports, sb.score_hits);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
